>>> design/utf8_to_modified_utf8_stream_assert.svh
// Assertion helpers used by the top-level module.
`ifndef UTF8_TO_MODIFIED_UTF8_STREAM_ASSERT_SVH
`define UTF8_TO_MODIFIED_UTF8_STREAM_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define U8M_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Condition holds at every edge out of reset.
`define U8M_ASSERT_ALWAYS(lbl, ck, rn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) \
        else $error(msg);

`endif

>>> design/u8m_pkg.sv
package u8m_pkg;

    typedef enum logic [1:0] {
        CMD_BYTE,
        CMD_NUL,
        CMD_SURR,
        CMD_MARK
    } cmd_kind_t;

    localparam int CP_W = 21;

    // Work item handed from front to back.
    typedef struct packed {
        cmd_kind_t         kind;
        logic [CP_W-1:0]   data;   // byte in [7:0], or code point minus 0x10000
        logic              fin;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_IDX_W = 2;
    localparam int FIFO_LVL_W = 3;

    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_NUL_LAST  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_SURR_LAST = 3'd5;
    localparam logic [STEP_W-1:0] STEP_SURR_LO   = 3'd3;

    localparam logic [7:0]      LEAD4_MASK = 8'hf8;
    localparam logic [7:0]      LEAD4_CODE = 8'hf0;
    localparam logic [7:0]      NUL_HI     = 8'hc0;
    localparam logic [7:0]      CONT_BASE  = 8'h80;
    localparam logic [7:0]      LEAD3_BASE = 8'he0;
    localparam logic [CP_W-1:0] SUPP_BASE  = 21'h10000;
    localparam logic [15:0]     SURR_HI    = 16'hd800;
    localparam logic [15:0]     SURR_LO    = 16'hdc00;

endpackage

>>> design/u8m_front.sv
module u8m_front
    import u8m_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] in_byte,
    input  logic       final_byte,
    input  fifo_stat_t q_stat,
    output logic       full,
    output logic       q_wr,
    output cmd_t       q_cmd
);

    logic [1:0]      pend_reg,  pend_next;
    logic [CP_W-1:0] gath_reg,  gath_next;
    logic            accept;
    logic            has_cmd;
    logic [CP_W-1:0] shifted;

    assign full   = q_stat.full;
    assign accept = push && !q_stat.full;

    always_comb
    begin
        pend_next  = pend_reg;
        gath_next  = gath_reg;
        has_cmd    = 1'b0;
        q_cmd.kind = CMD_MARK;
        q_cmd.data = '0;
        q_cmd.fin  = final_byte;
        shifted    = {gath_reg[CP_W-7:0], in_byte[5:0]};

        if (pend_reg != 2'd0)
        begin
            gath_next = shifted;
            pend_next = pend_reg - 2'd1;
            if (pend_reg == 2'd1 && shifted >= SUPP_BASE)
            begin
                has_cmd    = 1'b1;
                q_cmd.kind = CMD_SURR;
                q_cmd.data = shifted - SUPP_BASE;
            end
        end
        else if (in_byte == 8'h00)
        begin
            has_cmd    = 1'b1;
            q_cmd.kind = CMD_NUL;
        end
        else if ((in_byte & LEAD4_MASK) == LEAD4_CODE)
        begin
            gath_next = {{(CP_W-3){1'b0}}, in_byte[2:0]};
            pend_next = 2'd3;
        end
        else
        begin
            has_cmd    = 1'b1;
            q_cmd.kind = CMD_BYTE;
            q_cmd.data = {{(CP_W-8){1'b0}}, in_byte};
        end

        // end of string: drop any partial sequence and clear
        if (final_byte)
        begin
            pend_next = 2'd0;
            gath_next = '0;
        end
    end

    assign q_wr = accept && (has_cmd || final_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
            gath_reg <= '0;
        end
        else if (accept)
        begin
            pend_reg <= pend_next;
            gath_reg <= gath_next;
        end
    end

endmodule

>>> design/u8m_fifo.sv
module u8m_fifo
    import u8m_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr,
    input  cmd_t                  wr_cmd,
    input  logic                  rd,
    output cmd_t                  rd_cmd,
    output fifo_stat_t            stat,
    output logic [FIFO_LVL_W-1:0] level
);

    cmd_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_IDX_W-1:0] wp_reg, rp_reg;
    logic [FIFO_LVL_W-1:0] lvl_reg;
    logic                  do_wr, do_rd;

    assign stat.full  = (lvl_reg == FIFO_LVL_W'(FIFO_DEPTH));
    assign stat.empty = (lvl_reg == '0);
    assign do_wr      = wr && !stat.full;
    assign do_rd      = rd && !stat.empty;
    assign rd_cmd     = mem_reg[rp_reg];
    assign level      = lvl_reg;

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            lvl_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= wp_reg + 1'b1;
            if (do_rd)
                rp_reg <= rp_reg + 1'b1;
            if (do_wr && !do_rd)
                lvl_reg <= lvl_reg + 1'b1;
            else if (do_rd && !do_wr)
                lvl_reg <= lvl_reg - 1'b1;
        end
    end

endmodule

>>> design/u8m_back.sv
module u8m_back
    import u8m_pkg::*;
#(
    parameter int COUNT_BITS = 28
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  q_cmd,
    input  fifo_stat_t            q_stat,
    output logic                  q_rd,
    input  logic                  pop,
    output logic                  empty,
    output logic [7:0]            out_byte,
    output logic                  byte_valid,
    output logic                  end_of_string,
    output logic [COUNT_BITS-1:0] encoded_count
);

    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    logic [STEP_W-1:0]     step_reg;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic                  ov_reg;
    logic [7:0]            ob_reg;
    logic                  obv_reg;
    logic                  oend_reg;
    logic [COUNT_BITS-1:0] ocnt_reg;

    logic                  load, fire;
    logic [7:0]            res_byte;
    logic                  res_valid, res_last;
    logic [15:0]           hi_unit, lo_unit, unit;
    logic [COUNT_BITS-1:0] cnt_inc;

    assign empty         = !ov_reg;
    assign out_byte      = ob_reg;
    assign byte_valid    = obv_reg;
    assign end_of_string = oend_reg;
    assign encoded_count = ocnt_reg;

    // output register frees when empty or being taken
    assign load = !ov_reg || pop;
    assign fire = load && !q_stat.empty;

    assign hi_unit = SURR_HI | {5'd0, q_cmd.data[20:10]};
    assign lo_unit = SURR_LO | {6'd0, q_cmd.data[9:0]};
    assign unit    = (step_reg < STEP_SURR_LO) ? hi_unit : lo_unit;

    always_comb
    begin
        res_byte  = 8'h00;
        res_valid = 1'b1;
        res_last  = 1'b1;
        case (q_cmd.kind)
            CMD_BYTE:
            begin
                res_byte = q_cmd.data[7:0];
            end
            CMD_NUL:
            begin
                res_byte = (step_reg == '0) ? NUL_HI : CONT_BASE;
                res_last = (step_reg == STEP_NUL_LAST);
            end
            CMD_SURR:
            begin
                res_last = (step_reg == STEP_SURR_LAST);
                case (step_reg)
                    3'd0, 3'd3: res_byte = LEAD3_BASE | {4'd0, unit[15:12]};
                    3'd1, 3'd4: res_byte = CONT_BASE | {2'd0, unit[11:6]};
                    default:    res_byte = CONT_BASE | {2'd0, unit[5:0]};
                endcase
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    assign cnt_inc = (res_valid && cnt_reg != CMAX) ? cnt_reg + 1'b1 : cnt_reg;
    assign q_rd    = fire && res_last;

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            ob_reg   <= res_byte;
            obv_reg  <= res_valid;
            oend_reg <= q_cmd.fin && res_last;
            ocnt_reg <= cnt_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg   <= 1'b0;
            step_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (load)
                ov_reg <= !q_stat.empty;
            if (fire)
            begin
                step_reg <= res_last ? '0 : step_reg + 1'b1;
                cnt_reg  <= (q_cmd.fin && res_last) ? '0 : cnt_inc;
            end
        end
    end

endmodule

>>> design/utf8_to_modified_utf8_stream.sv
// Channel   Handshake        Words
// input     push / full      in_byte, final_byte
// result    empty / pop      out_byte, byte_valid, end_of_string, encoded_count
//
// The front classifies one byte per cycle while not full and queues a command
// (4 deep). The back emits one result word per cycle, unless a result is held
// for pop, from the queue head: a surrogate pair gives 6 words, NUL 2, other
// words 1. Input goes through the queue and the output register to the result.
// Reset clears the decoder state, queue and byte count; no init sweep.
// full rises only when the queue is full; a stalled pop holds the result word.
`include "utf8_to_modified_utf8_stream_assert.svh"

module utf8_to_modified_utf8_stream
    import u8m_pkg::*;
#(
    parameter int COUNT_BITS = 28
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            in_byte,
    input  logic                  final_byte,
    output logic                  empty,
    input  logic                  pop,
    output logic [7:0]            out_byte,
    output logic                  byte_valid,
    output logic                  end_of_string,
    output logic [COUNT_BITS-1:0] encoded_count
);

    fifo_stat_t            q_stat;
    logic                  q_wr, q_rd;
    cmd_t                  wr_cmd, rd_cmd;
    logic [FIFO_LVL_W-1:0] q_level;

    u8m_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .in_byte    (in_byte),
        .final_byte (final_byte),
        .q_stat     (q_stat),
        .full       (full),
        .q_wr       (q_wr),
        .q_cmd      (wr_cmd)
    );

    u8m_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_wr),
        .wr_cmd (wr_cmd),
        .rd     (q_rd),
        .rd_cmd (rd_cmd),
        .stat   (q_stat),
        .level  (q_level)
    );

    u8m_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_cmd         (rd_cmd),
        .q_stat        (q_stat),
        .q_rd          (q_rd),
        .pop           (pop),
        .empty         (empty),
        .out_byte      (out_byte),
        .byte_valid    (byte_valid),
        .end_of_string (end_of_string),
        .encoded_count (encoded_count)
    );

    `U8M_ASSERT_IMPLY(a_marker_ends, clk, rst_n, !empty && !byte_valid, end_of_string, "marker word without end_of_string")
    `U8M_ASSERT_IMPLY(a_data_counted, clk, rst_n, !empty && byte_valid, encoded_count != '0, "data word with zero count")
    `U8M_ASSERT_ALWAYS(a_queue_level, clk, rst_n, q_level <= FIFO_LVL_W'(FIFO_DEPTH), "command queue overrun")
    `U8M_ASSERT_IMPLY(a_no_read_empty, clk, rst_n, q_rd, !q_stat.empty, "queue read while empty")

endmodule
